// ===== rtl/sabg_pkg.sv =====
// Package: widths, defaults and constants shared by the ack bitmap generator files.
`timescale 1ns / 1ps
package sabg_pkg;
   localparam int SEQ_BITS_DEFAULT = 8;
   localparam int LOOKBACK_DEFAULT = 64;
   localparam int SEQ_ID_WIDTH     = 8;
   localparam int ACK_SPAN         = 32;
endpackage

// ===== rtl/sabg_if.sv =====
// Interfaces: valid/ready channels for sequence words and ack words.
`timescale 1ns / 1ps
interface sabg_req_if
   import sabg_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [SEQ_ID_WIDTH-1:0] seq_id;
   modport source (output valid, output seq_id, input ready);
   modport sink   (input valid, input seq_id, output ready);
endinterface

interface sabg_rsp_if
   import sabg_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [SEQ_ID_WIDTH-1:0] latest_seq;
   logic [ACK_SPAN-1:0]     ack_mask;
   modport source (output valid, output latest_seq, output ack_mask, input ready);
   modport sink   (input valid, input latest_seq, input ack_mask, output ready);
endinterface

// ===== rtl/selective_ack_bitmap_generator.sv =====
// Selective ack bitmap generator: ring memory of received sequence numbers with two scans.
// Per accepted word, scan one reads the N older frames held (0..LOOKBACK), if any, for the
// latest sequence; scan two reads the new word and those frames to build the ack mask. One
// word in flight at a time; two read scans over the single-port ring memory set the rate.
// A waiting result word does not block the next request word.
// Reset (synchronous, active high) empties the ring; ring contents are left as they are.
`timescale 1ns / 1ps
module selective_ack_bitmap_generator
   import sabg_pkg::*;
#(
   parameter int SEQ_BITS = SEQ_BITS_DEFAULT,
   parameter int LOOKBACK = LOOKBACK_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sabg_req_if.sink   req_bus,
   sabg_rsp_if.source rsp_bus
);
   localparam int RING_DEPTH = LOOKBACK + 1;
   localparam int AW   = $clog2(RING_DEPTH);
   localparam int CW   = $clog2(RING_DEPTH + 1);
   localparam int EXTW = SEQ_BITS + SEQ_ID_WIDTH;
   localparam int DW   = (SEQ_BITS > 6) ? SEQ_BITS : 6;
   localparam logic [SEQ_BITS-1:0] HALF = SEQ_BITS'(1) << (SEQ_BITS - 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_SCAN2, S_DRAIN, S_DONE} state_type;

   function automatic logic more_recent(input logic [SEQ_BITS-1:0] a,
                                        input logic [SEQ_BITS-1:0] b);
      logic [SEQ_BITS-1:0] ab;
      logic [SEQ_BITS-1:0] ba;
      ab = a - b;
      ba = b - a;
      return ((a > b) && (ab <= HALF)) || ((b > a) && (ba > HALF));
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
      return (s == '0) ? LAST_SLOT : s - AW'(1);
   endfunction

   logic [SEQ_BITS-1:0] ring_mem [RING_DEPTH];

   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       newest_ff, newest_in;
   logic [CW-1:0]       older_ff, older_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [SEQ_BITS-1:0] latest_ff, latest_in;
   logic [ACK_SPAN-1:0] mask_ff, mask_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                rd_phase2_ff, rd_phase2_in;
   logic [SEQ_BITS-1:0] rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SEQ_ID_WIDTH-1:0] rsp_seq_ff, rsp_seq_in;
   logic [ACK_SPAN-1:0] rsp_mask_ff, rsp_mask_in;

   logic                accept;
   logic                rd_en;
   logic [AW-1:0]       wr_slot;
   logic [EXTW-1:0]     seq_ext;
   logic [SEQ_BITS-1:0] seq_val;
   logic [EXTW-1:0]     latest_ext;
   logic [SEQ_BITS-1:0] gap;
   logic [DW-1:0]       gap_ext;
   logic                hit;

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign accept             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.latest_seq = rsp_seq_ff;
   assign rsp_bus.ack_mask   = rsp_mask_ff;

   assign seq_ext    = EXTW'(req_bus.seq_id);
   assign seq_val    = seq_ext[SEQ_BITS-1:0];
   assign wr_slot    = (fill_ff == '0) ? '0 :
                       ((newest_ff == LAST_SLOT) ? '0 : newest_ff + AW'(1));
   assign latest_ext = EXTW'(latest_ff);
   assign rd_en      = (state_ff == S_SCAN1) || (state_ff == S_SCAN2);

   assign gap     = latest_ff - rd_data_ff;
   assign gap_ext = DW'(gap);
   assign hit     = (rd_data_ff != latest_ff) && !more_recent(rd_data_ff, latest_ff) &&
                    (gap_ext >= DW'(1)) && (gap_ext <= DW'(ACK_SPAN));

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wr_slot] <= seq_val;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      newest_in    = newest_ff;
      older_in     = older_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      latest_in    = latest_ff;
      mask_in      = mask_ff;
      rd_valid_in  = 1'b0;
      rd_phase2_in = rd_phase2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_seq_in   = rsp_seq_ff;
      rsp_mask_in  = rsp_mask_ff;

      if (rd_valid_ff) begin
         if (!rd_phase2_ff) begin
            if (more_recent(rd_data_ff, latest_ff)) begin
               latest_in = rd_data_ff;
            end
         end else begin
            for (int i = 0; i < ACK_SPAN; i++) begin
               if (hit && (gap_ext == DW'(i + 1))) begin
                  mask_in[i] = 1'b1;
               end
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               newest_in = wr_slot;
               fill_in   = (fill_ff == CW'(RING_DEPTH)) ? fill_ff : fill_ff + CW'(1);
               older_in  = fill_in - CW'(1);
               latest_in = seq_val;
               mask_in   = '0;
               if (older_in == '0) begin
                  state_in = S_SCAN2;
                  ptr_in   = wr_slot;
                  cnt_in   = CW'(1);
               end else begin
                  state_in = S_SCAN1;
                  ptr_in   = slot_dec(wr_slot);
                  cnt_in   = older_in;
               end
            end
         end
         S_SCAN1: begin
            rd_valid_in  = 1'b1;
            rd_phase2_in = 1'b0;
            ptr_in       = slot_dec(ptr_ff);
            cnt_in       = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_SCAN2;
               ptr_in   = newest_ff;
               cnt_in   = older_ff + CW'(1);
            end
         end
         S_SCAN2: begin
            rd_valid_in  = 1'b1;
            rd_phase2_in = 1'b1;
            ptr_in       = slot_dec(ptr_ff);
            cnt_in       = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = latest_ext[SEQ_ID_WIDTH-1:0];
               rsp_mask_in  = mask_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         newest_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         newest_ff    <= newest_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      older_ff     <= older_in;
      cnt_ff       <= cnt_in;
      ptr_ff       <= ptr_in;
      latest_ff    <= latest_in;
      mask_ff      <= mask_in;
      rd_phase2_ff <= rd_phase2_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_mask_ff  <= rsp_mask_in;
   end
endmodule

// ===== sim/selective_ack_bitmap_generator_test.sv =====
// Testbench: self-checking valid/ready test of the ack bitmap generator with an ack predictor.
`timescale 1ns / 1ps
module selective_ack_bitmap_generator_test
   import sabg_pkg::*;
();

   localparam int SEQ_BITS    = SEQ_BITS_DEFAULT;
   localparam int LOOKBACK    = LOOKBACK_DEFAULT;
   localparam int RING_SLOTS  = LOOKBACK + 1;
   localparam int SEQ_MASK    = (1 << SEQ_BITS) - 1;
   localparam int HALF_SPACE  = (1 << SEQ_BITS) / 2;
   localparam int PHASE_WORDS = 333;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_WAIT  = 2 * LOOKBACK + 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int N_DIRECTED  = 21;

   typedef struct packed {
      logic [SEQ_ID_WIDTH-1:0] latest;
      logic [ACK_SPAN-1:0]     mask;
   } ack_word_type;

   typedef struct packed {
      bit           typed;
      ack_word_type ack;
   } known_ack_type;

   typedef struct packed {
      logic [SEQ_ID_WIDTH-1:0] seq;
      bit                      typed;
      ack_word_type            ack;
   } seq_row_type;

   logic clock;
   logic reset;

   sabg_req_if req_bus ();
   sabg_rsp_if rsp_bus ();

   selective_ack_bitmap_generator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // ack predictor state
   int ring_copy [RING_SLOTS];
   int held_count;
   int head_slot;

   ack_word_type  pending_acks [$];
   known_ack_type typed_acks [$];
   seq_row_type   seq_rows [N_DIRECTED];

   int fail_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bit is_newer(int a, int b);
      return (a > b && a - b <= HALF_SPACE) || (b > a && b - a > HALF_SPACE);
   endfunction

   function automatic ack_word_type predict_ack(logic [SEQ_ID_WIDTH-1:0] seq);
      ack_word_type w;
      int           older;
      int           best;
      int           s;
      int           d;
      if (held_count > 0) begin
         head_slot = (head_slot + 1) % RING_SLOTS;
      end else begin
         head_slot = 0;
      end
      ring_copy[head_slot] = int'(seq) & SEQ_MASK;
      if (held_count < RING_SLOTS) begin
         held_count++;
      end
      older = held_count - 1;
      best  = ring_copy[head_slot];
      for (int k = 1; k <= older; k++) begin
         s = ring_copy[(head_slot + RING_SLOTS - k) % RING_SLOTS];
         if (is_newer(s, best)) begin
            best = s;
         end
      end
      w.mask = '0;
      for (int k = 0; k <= older; k++) begin
         s = ring_copy[(head_slot + RING_SLOTS - k) % RING_SLOTS];
         if (s == best || is_newer(s, best)) begin
            continue;
         end
         d = (best - s) & SEQ_MASK;
         if (d >= 1 && d <= ACK_SPAN) begin
            w.mask[d-1] = 1'b1;
         end
      end
      w.latest = SEQ_ID_WIDTH'(best & SEQ_MASK);
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // sampling: request words feed the predictor, ack words are checked in order
   always @(posedge clock) begin
      known_ack_type k;
      ack_word_type  w;
      ack_word_type  e;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            w = predict_ack(req_bus.seq_id);
            k = typed_acks.pop_front();
            pending_acks.push_back(k.typed ? k.ack : w);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_acks.size() == 0) begin
               report_mismatch("unexpected word", {24'h0, rsp_bus.latest_seq}, 32'h0);
            end else begin
               e = pending_acks.pop_front();
               if (rsp_bus.latest_seq !== e.latest) begin
                  report_mismatch("latest_seq", {24'h0, rsp_bus.latest_seq}, {24'h0, e.latest});
               end
               if (rsp_bus.ack_mask !== e.mask) begin
                  report_mismatch("ack_mask", rsp_bus.ack_mask, e.mask);
               end
            end
         end
      end
   end

   // receiver: random backpressure, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_seq(logic [SEQ_ID_WIDTH-1:0] seq, known_ack_type known);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      typed_acks.push_back(known);
      req_bus.valid  <= 1'b1;
      req_bus.seq_id <= seq;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_stream(int count);
      int cur;
      int pick;
      int seq;
      cur = $urandom_range(0, SEQ_MASK);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            cur = cur + 1;
            seq = cur;
         end else if (pick < 70) begin
            cur = cur + $urandom_range(2, 5);
            seq = cur;
         end else if (pick < 80) begin
            seq = cur - $urandom_range(1, 40);
         end else if (pick < 85) begin
            seq = cur;
         end else if (pick < 90) begin
            cur = cur + HALF_SPACE + $urandom_range(0, 6) - 3;
            seq = cur;
         end else begin
            seq = $urandom_range(0, SEQ_MASK);
         end
         send_seq(SEQ_ID_WIDTH'(seq & SEQ_MASK), '0);
      end
   endtask

   initial begin
      fail_count    = 0;
      cycle_count   = 0;
      held_count    = 0;
      head_slot     = 0;
      hold_request  = 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 49;
      for (int i = 0; i < RING_SLOTS; i++) ring_copy[i] = 0;
      seq_rows = '{
         '{8'h05, 1'b1, '{8'h05, 32'h0000_0000}},
         '{8'h04, 1'b1, '{8'h05, 32'h0000_0001}},
         '{8'h06, 1'b1, '{8'h06, 32'h0000_0003}},
         '{8'h26, 1'b1, '{8'h26, 32'h8000_0000}},
         '{8'hFF, 1'b0, '{8'h00, 32'h0}},
         '{8'h00, 1'b0, '{8'h00, 32'h0}},
         '{8'h80, 1'b0, '{8'h00, 32'h0}},
         '{8'h7F, 1'b0, '{8'h00, 32'h0}},
         '{8'h26, 1'b0, '{8'h00, 32'h0}},
         '{8'h26, 1'b0, '{8'h00, 32'h0}},
         '{8'hA6, 1'b0, '{8'h00, 32'h0}},
         '{8'h01, 1'b0, '{8'h00, 32'h0}},
         '{8'h02, 1'b0, '{8'h00, 32'h0}},
         '{8'hFE, 1'b0, '{8'h00, 32'h0}},
         '{8'hAA, 1'b0, '{8'h00, 32'h0}},
         '{8'h55, 1'b0, '{8'h00, 32'h0}},
         '{8'h00, 1'b0, '{8'h00, 32'h0}},
         '{8'h80, 1'b0, '{8'h00, 32'h0}},
         '{8'hC0, 1'b0, '{8'h00, 32'h0}},
         '{8'h40, 1'b0, '{8'h00, 32'h0}},
         '{8'h25, 1'b0, '{8'h00, 32'h0}}
      };
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.seq_id <= '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_seq(seq_rows[i].seq, '{seq_rows[i].typed, seq_rows[i].ack});
      end
      send_stream(PHASE_WORDS);

      send_idle_pct = 49;
      recv_idle_pct = 36;
      send_stream(PHASE_WORDS);

      // no idling; receiver first stalls long so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_stream(PHASE_WORDS);
      req_bus.valid <= 1'b0;

      while (pending_acks.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== selective_ack_bitmap_generator.f =====
rtl/sabg_pkg.sv
rtl/sabg_if.sv
rtl/selective_ack_bitmap_generator.sv
sim/selective_ack_bitmap_generator_test.sv
